/* design/vsdd_pkg.sv */
// Shared types and constants of the visual servo drive decider.
// Used by vsdd_decide and visual_servo_drive_decider; depends on nothing.
package vsdd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_LEFT      = 3'd0,
    CFG_WINDOW_RIGHT     = 3'd1,
    CFG_TARGET_CENTER_X  = 3'd2,
    CFG_TARGET_WIDTH     = 3'd3,
    CFG_TARGET_SIZE      = 3'd4,
    CFG_CENTER_TOL       = 3'd5,
    CFG_SIZE_TOL         = 3'd6,
    CFG_STABLE_FRAMES    = 3'd7
  } cfg_reg_t;

  localparam int STABLE_BITS  = 10;
  localparam int SETTLED_BITS = 16;

  // Reset values before truncation to the coordinate width
  localparam int RST_WINDOW_RIGHT = 4095;
  localparam int RST_CENTER_X     = 2048;
  localparam int RST_TARGET_SIZE  = 155;

  typedef enum logic [3:0] {
    ACT_IDLE          = 4'd0,
    ACT_SEARCH_LEFT   = 4'd1,
    ACT_SEARCH_RIGHT  = 4'd2,
    ACT_BUCKET_SEARCH = 4'd3,
    ACT_BALL_LEFT     = 4'd4,
    ACT_BALL_RIGHT    = 4'd5,
    ACT_BUCKET_LEFT   = 4'd6,
    ACT_BUCKET_RIGHT  = 4'd7,
    ACT_FINE_LEFT     = 4'd8,
    ACT_FINE_RIGHT    = 4'd9,
    ACT_BALL_FWD      = 4'd10,
    ACT_BALL_BACK     = 4'd11,
    ACT_BUCKET_FWD    = 4'd12,
    ACT_BUCKET_BACK   = 4'd13,
    ACT_BALL_READY    = 4'd14,
    ACT_BUCKET_READY  = 4'd15
  } action_t;

  // Wheel speeds, signed percent
  localparam logic signed [7:0] SPD_MAX        = 8'sd100;
  localparam logic signed [7:0] SPD_SEARCH     = 8'sd30;
  localparam logic signed [7:0] SPD_COARSE     = 8'sd30;
  localparam logic signed [7:0] SPD_NEAR       = 8'sd12;
  localparam logic signed [7:0] SPD_FINE       = 8'sd8;
  localparam logic signed [7:0] SPD_BALL_FWD   = 8'sd35;
  localparam logic signed [7:0] SPD_BALL_SLOW  = 8'sd8;
  localparam logic signed [7:0] SPD_BUCKET_FWD = 8'sd25;
  localparam logic signed [7:0] SPD_BACK       = -8'sd12;
  localparam logic signed [7:0] SPD_BUCKET_SRCH = 8'sd12;

  typedef struct packed {
    logic signed [7:0] spd_left;
    logic signed [7:0] spd_right;
    action_t           action_code;
    logic              is_idle;
    logic              reached;
  } result_t;

endpackage

/* design/vsdd_decide.sv */
// Combinational drive decision for one registered observation.
// Depends on vsdd_pkg; instantiated by visual_servo_drive_decider.
module vsdd_decide #(
  parameter int COORD_BITS = 12
) (
  input  logic                              visible,
  input  logic                              bucket,
  input  logic [COORD_BITS-1:0]             obs_x,
  input  logic [COORD_BITS-1:0]             box_width,
  input  logic [COORD_BITS-1:0]             box_height,
  input  logic [COORD_BITS-1:0]             window_left,
  input  logic [COORD_BITS-1:0]             window_right,
  input  logic [COORD_BITS-1:0]             center_x,
  input  logic [COORD_BITS-1:0]             near_width,
  input  logic [COORD_BITS-1:0]             stop_size,
  input  logic [COORD_BITS-1:0]             center_tol,
  input  logic [COORD_BITS-1:0]             size_tol,
  input  logic [vsdd_pkg::STABLE_BITS-1:0]  stable_needed,
  input  logic                              last_valid,
  input  logic [COORD_BITS-1:0]             last_x,
  input  logic [vsdd_pkg::SETTLED_BITS-1:0] settled,
  output vsdd_pkg::result_t                 result,
  output logic [vsdd_pkg::SETTLED_BITS-1:0] settled_nxt
);

  localparam int N  = COORD_BITS;
  localparam int W1 = N + 1;
  localparam int W2 = N + 2;
  localparam int W3 = N + 3;
  localparam int W5 = N + 5;

  logic [N-1:0]      pos;
  logic [N-1:0]      cx_err;
  logic [W2-1:0]     width_x3;
  logic [W1-1:0]     lim;
  logic              near;
  logic signed [7:0] turn_spd;
  logic              cx_below;
  logic              too_small;
  logic              too_big;
  logic              ball_slow;
  logic [W1-1:0]     pos_p1;
  logic              bucket_fwd;
  logic              bucket_far;
  logic              ready;
  logic [vsdd_pkg::SETTLED_BITS-1:0] settled_inc;
  logic signed [7:0] l_spd;
  logic signed [7:0] r_spd;
  vsdd_pkg::action_t act;

  always_comb begin
    if (bucket) begin
      pos = (box_width < box_height) ? box_width : box_height;
    end else begin
      pos = (box_width > box_height) ? box_width : box_height;
    end
  end

  assign cx_below = obs_x < center_x;
  assign cx_err   = cx_below ? (center_x - obs_x) : (obs_x - center_x);

  // Ball near limit is floor(3*w/2)
  assign width_x3 = W2'(near_width) + W2'({near_width, 1'b0});
  assign lim      = bucket ? W1'(near_width) : width_x3[W2-1:1];
  assign near     = W1'(cx_err) < lim;
  assign turn_spd = near ? vsdd_pkg::SPD_NEAR : vsdd_pkg::SPD_COARSE;

  assign too_small = (W1'(pos) + W1'(size_tol)) < W1'(stop_size);
  assign too_big   = W1'(pos) > (W1'(stop_size) + W1'(size_tol));
  // 8*pos > 10*size, halved on both sides
  assign ball_slow = W3'({pos, 2'b00}) > (W3'({stop_size, 2'b00}) + W3'(stop_size));

  // size < floor(2.1*target) done exactly as 10*(size+1) <= 21*target
  assign pos_p1     = W1'(pos) + W1'(1);
  assign bucket_fwd = (W5'(pos_p1) * W5'(10)) <= (W5'(stop_size) * W5'(21));
  assign bucket_far = W2'(pos) > (W2'(stop_size) * W2'(3));

  assign settled_inc = (&settled) ? settled : settled + 1'b1;

  always_comb begin
    l_spd = '0;
    r_spd = '0;
    act   = vsdd_pkg::ACT_IDLE;
    ready = 1'b0;
    if (!visible) begin
      if (bucket) begin
        l_spd = vsdd_pkg::SPD_BUCKET_SRCH;
        r_spd = -vsdd_pkg::SPD_BUCKET_SRCH;
        act   = vsdd_pkg::ACT_BUCKET_SEARCH;
      end else if (last_valid) begin
        if (last_x < center_x) begin
          l_spd = -vsdd_pkg::SPD_SEARCH;
          r_spd = vsdd_pkg::SPD_SEARCH;
          act   = vsdd_pkg::ACT_SEARCH_LEFT;
        end else begin
          l_spd = vsdd_pkg::SPD_SEARCH;
          r_spd = -vsdd_pkg::SPD_SEARCH;
          act   = vsdd_pkg::ACT_SEARCH_RIGHT;
        end
      end
    end else if (obs_x < window_left) begin
      l_spd = -turn_spd;
      r_spd = turn_spd;
      act   = bucket ? vsdd_pkg::ACT_BUCKET_LEFT : vsdd_pkg::ACT_BALL_LEFT;
    end else if (obs_x > window_right) begin
      l_spd = turn_spd;
      r_spd = -turn_spd;
      act   = bucket ? vsdd_pkg::ACT_BUCKET_RIGHT : vsdd_pkg::ACT_BALL_RIGHT;
    end else if (!bucket) begin
      if (cx_err > center_tol) begin
        if (cx_below) begin
          l_spd = -vsdd_pkg::SPD_FINE;
          r_spd = vsdd_pkg::SPD_FINE;
          act   = vsdd_pkg::ACT_FINE_LEFT;
        end else begin
          l_spd = vsdd_pkg::SPD_FINE;
          r_spd = -vsdd_pkg::SPD_FINE;
          act   = vsdd_pkg::ACT_FINE_RIGHT;
        end
      end else if (too_small) begin
        l_spd = ball_slow ? vsdd_pkg::SPD_BALL_SLOW : vsdd_pkg::SPD_BALL_FWD;
        r_spd = l_spd;
        act   = vsdd_pkg::ACT_BALL_FWD;
      end else if (too_big) begin
        l_spd = vsdd_pkg::SPD_BACK;
        r_spd = vsdd_pkg::SPD_BACK;
        act   = vsdd_pkg::ACT_BALL_BACK;
      end else begin
        act   = vsdd_pkg::ACT_BALL_READY;
        ready = 1'b1;
      end
    end else begin
      if (bucket_fwd) begin
        l_spd = vsdd_pkg::SPD_BUCKET_FWD;
        r_spd = vsdd_pkg::SPD_BUCKET_FWD;
        act   = vsdd_pkg::ACT_BUCKET_FWD;
      end else if (bucket_far) begin
        l_spd = vsdd_pkg::SPD_BACK;
        r_spd = vsdd_pkg::SPD_BACK;
        act   = vsdd_pkg::ACT_BUCKET_BACK;
      end else begin
        act   = vsdd_pkg::ACT_BUCKET_READY;
        ready = 1'b1;
      end
    end
  end

  assign settled_nxt = ready ? settled_inc : '0;

  assign result.spd_left    = l_spd;
  assign result.spd_right   = r_spd;
  assign result.action_code = act;
  assign result.is_idle     = (l_spd == 8'sd0) && (r_spd == 8'sd0);
  assign result.reached     = ready &&
                              (settled_inc > vsdd_pkg::SETTLED_BITS'(stable_needed));

endmodule

/* design/visual_servo_drive_decider.sv */
// Top level of the visual servo drive decider: configuration registers,
// input register, tracking state and result register. Depends on vsdd_pkg and vsdd_decide.

// One observation per cycle unless out_stall holds the result register: a
// transfer is registered in the input register, decided by combinational
// compare logic and written to the result register as that register drains or
// is empty. The only feedback is the settled-frame counter and the last seen
// column, updated as each item moves into the result register. in_stall rises
// only while the input register is full and the result register cannot drain.
// cfg_ready is always high; write configuration only while the block is idle.
module visual_servo_drive_decider #(
  parameter int COORD_BITS = 12,
  localparam int CfgBits = (COORD_BITS > vsdd_pkg::STABLE_BITS) ?
                           COORD_BITS : vsdd_pkg::STABLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vsdd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CfgBits-1:0]                cfg_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_target_visible,
  input  logic                              in_bucket_mode,
  input  logic [COORD_BITS-1:0]             in_target_x,
  input  logic [COORD_BITS-1:0]             in_box_width,
  input  logic [COORD_BITS-1:0]             in_box_height,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [7:0]                 out_left_speed,
  output logic signed [7:0]                 out_right_speed,
  output logic [3:0]                        out_action_code,
  output logic                              out_is_idle,
  output logic                              out_reached
);

  // Configuration
  logic [COORD_BITS-1:0]            window_left_r;
  logic [COORD_BITS-1:0]            window_right_r;
  logic [COORD_BITS-1:0]            center_x_r;
  logic [COORD_BITS-1:0]            near_width_r;
  logic [COORD_BITS-1:0]            stop_size_r;
  logic [COORD_BITS-1:0]            center_tol_r;
  logic [COORD_BITS-1:0]            size_tol_r;
  logic [vsdd_pkg::STABLE_BITS-1:0] stable_needed_r;

  // Input register
  logic                  s1_vld_r;
  logic                  s1_visible_r;
  logic                  s1_bucket_r;
  logic [COORD_BITS-1:0] s1_x_r;
  logic [COORD_BITS-1:0] s1_w_r;
  logic [COORD_BITS-1:0] s1_h_r;

  // Tracking state
  logic [vsdd_pkg::SETTLED_BITS-1:0] settled_r;
  logic [vsdd_pkg::SETTLED_BITS-1:0] settled_nxt;
  logic                              last_valid_r;
  logic [COORD_BITS-1:0]             last_x_r;

  // Result register
  logic              out_vld_r;
  vsdd_pkg::result_t out_res_r;
  vsdd_pkg::result_t res_nxt;

  logic out_adv;
  logic s1_fire;
  logic in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_left_r   <= '0;
      window_right_r  <= COORD_BITS'(vsdd_pkg::RST_WINDOW_RIGHT);
      center_x_r      <= COORD_BITS'(vsdd_pkg::RST_CENTER_X);
      near_width_r    <= '0;
      stop_size_r     <= COORD_BITS'(vsdd_pkg::RST_TARGET_SIZE);
      center_tol_r    <= '0;
      size_tol_r      <= '0;
      stable_needed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (vsdd_pkg::cfg_reg_t'(cfg_index))
        vsdd_pkg::CFG_WINDOW_LEFT:     window_left_r   <= cfg_data[COORD_BITS-1:0];
        vsdd_pkg::CFG_WINDOW_RIGHT:    window_right_r  <= cfg_data[COORD_BITS-1:0];
        vsdd_pkg::CFG_TARGET_CENTER_X: center_x_r      <= cfg_data[COORD_BITS-1:0];
        vsdd_pkg::CFG_TARGET_WIDTH:    near_width_r    <= cfg_data[COORD_BITS-1:0];
        vsdd_pkg::CFG_TARGET_SIZE:     stop_size_r     <= cfg_data[COORD_BITS-1:0];
        vsdd_pkg::CFG_CENTER_TOL:      center_tol_r    <= cfg_data[COORD_BITS-1:0];
        vsdd_pkg::CFG_SIZE_TOL:        size_tol_r      <= cfg_data[COORD_BITS-1:0];
        vsdd_pkg::CFG_STABLE_FRAMES:
          stable_needed_r <= cfg_data[vsdd_pkg::STABLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register drains or is empty, so the input
  // register may advance in the same cycle.
  assign out_adv  = !out_vld_r || !out_stall;
  assign s1_fire  = s1_vld_r && out_adv;
  assign in_stall = s1_vld_r && !out_adv;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_visible_r <= in_target_visible;
      s1_bucket_r  <= in_bucket_mode;
      s1_x_r       <= in_target_x;
      s1_w_r       <= in_box_width;
      s1_h_r       <= in_box_height;
    end
  end

  vsdd_decide #(
    .COORD_BITS (COORD_BITS)
  ) u_decide (
    .visible       (s1_visible_r),
    .bucket        (s1_bucket_r),
    .obs_x         (s1_x_r),
    .box_width     (s1_w_r),
    .box_height    (s1_h_r),
    .window_left   (window_left_r),
    .window_right  (window_right_r),
    .center_x      (center_x_r),
    .near_width    (near_width_r),
    .stop_size     (stop_size_r),
    .center_tol    (center_tol_r),
    .size_tol      (size_tol_r),
    .stable_needed (stable_needed_r),
    .last_valid    (last_valid_r),
    .last_x        (last_x_r),
    .settled       (settled_r),
    .result        (res_nxt),
    .settled_nxt   (settled_nxt)
  );

  // Commit tracking state as the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settled_r    <= '0;
      last_valid_r <= 1'b0;
      last_x_r     <= '0;
    end else if (s1_fire) begin
      settled_r <= settled_nxt;
      if (s1_visible_r) begin
        last_valid_r <= 1'b1;
        last_x_r     <= s1_x_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_left_speed  = out_res_r.spd_left;
  assign out_right_speed = out_res_r.spd_right;
  assign out_action_code = out_res_r.action_code;
  assign out_is_idle     = out_res_r.is_idle;
  assign out_reached     = out_res_r.reached;

  // Reached is only reported with a ready action
  a_reached_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.reached) |->
      (out_res_r.action_code == vsdd_pkg::ACT_BALL_READY ||
       out_res_r.action_code == vsdd_pkg::ACT_BUCKET_READY))
    else $error("reached without ready action");

  // A missing target clears the settled counter
  a_lost_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_visible_r) |=> (settled_r == '0))
    else $error("settled count not cleared on lost target");

  // The input side stalls only while the input register is held
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled without backpressure");

  // An item leaving the input register lands in the result register
  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_vld_r)
    else $error("item lost between stages");

  // Wheel commands stay within full scale
  a_speed_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |->
      (out_res_r.spd_left <= vsdd_pkg::SPD_MAX &&
       out_res_r.spd_left >= -vsdd_pkg::SPD_MAX &&
       out_res_r.spd_right <= vsdd_pkg::SPD_MAX &&
       out_res_r.spd_right >= -vsdd_pkg::SPD_MAX))
    else $error("wheel speed out of range");

endmodule

/* tb/tb_visual_servo_drive_decider.sv */
// Self-checking testbench for visual_servo_drive_decider: directed frames, then
// random frames under several register settings, each result checked against a
// behavioral drive predictor or typed command. Depends on vsdd_pkg and the RTL.
module tb_visual_servo_drive_decider;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_FRAMES = 128;

  typedef struct packed {
    logic        visible;
    logic        bucket;
    logic [11:0] x;
    logic [11:0] w;
    logic [11:0] h;
  } obs_t;

  typedef struct {
    bit                new_setting;
    obs_t              o;
    bit                typed;
    vsdd_pkg::result_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  vsdd_pkg::cfg_reg_t cfg_index;
  logic [11:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_target_visible;
  logic               in_bucket_mode;
  logic [11:0]        in_target_x;
  logic [11:0]        in_box_width;
  logic [11:0]        in_box_height;
  logic               out_valid;
  logic               out_stall;
  logic signed [7:0]  out_left_speed;
  logic signed [7:0]  out_right_speed;
  logic [3:0]         out_action_code;
  logic               out_is_idle;
  logic               out_reached;

  // predictor copy of registers and tracking state
  int cfg_q [8];
  int settled_cnt;
  bit seen_any;
  int seen_x;

  vsdd_pkg::result_t drive_q [$];
  dir_row_t          dir_tab [$];

  int          errors;
  int          frames_sent;
  int          results_seen;
  int          settings_used;
  int unsigned cycle_cnt;
  bit          hold_req;
  bit          tx_steady;

  visual_servo_drive_decider dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target_visible (in_target_visible),
    .in_bucket_mode    (in_bucket_mode),
    .in_target_x       (in_target_x),
    .in_box_width      (in_box_width),
    .in_box_height     (in_box_height),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_speed    (out_left_speed),
    .out_right_speed   (out_right_speed),
    .out_action_code   (out_action_code),
    .out_is_idle       (out_is_idle),
    .out_reached       (out_reached)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [11:0] clip12(int v);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic vsdd_pkg::result_t drive_cmd(int l, int r, vsdd_pkg::action_t act,
                                                  bit done);
    vsdd_pkg::result_t c;
    c.spd_left    = l[7:0];
    c.spd_right   = r[7:0];
    c.action_code = act;
    c.is_idle     = (l == 0 && r == 0);
    c.reached     = done;
    return c;
  endfunction

  // Decide the wheel command for one frame and advance the tracking state.
  function automatic vsdd_pkg::result_t decide_drive(obs_t o);
    int cx, w, h, pos, off, lim, spd, err;
    int wl, wr, tcx, tw, tsz, ctol, stol;
    cx   = o.x;
    w    = o.w;
    h    = o.h;
    wl   = cfg_q[vsdd_pkg::CFG_WINDOW_LEFT];
    wr   = cfg_q[vsdd_pkg::CFG_WINDOW_RIGHT];
    tcx  = cfg_q[vsdd_pkg::CFG_TARGET_CENTER_X];
    tw   = cfg_q[vsdd_pkg::CFG_TARGET_WIDTH];
    tsz  = cfg_q[vsdd_pkg::CFG_TARGET_SIZE];
    ctol = cfg_q[vsdd_pkg::CFG_CENTER_TOL];
    stol = cfg_q[vsdd_pkg::CFG_SIZE_TOL];
    if (!o.visible) begin
      settled_cnt = 0;
      if (o.bucket) return drive_cmd(12, -12, vsdd_pkg::ACT_BUCKET_SEARCH, 1'b0);
      if (!seen_any) return drive_cmd(0, 0, vsdd_pkg::ACT_IDLE, 1'b0);
      if (seen_x < tcx) return drive_cmd(-30, 30, vsdd_pkg::ACT_SEARCH_LEFT, 1'b0);
      return drive_cmd(30, -30, vsdd_pkg::ACT_SEARCH_RIGHT, 1'b0);
    end
    seen_x   = cx;
    seen_any = 1'b1;
    if (o.bucket) pos = (w < h) ? w : h;
    else pos = (w > h) ? w : h;
    off = tcx - cx;
    if (off < 0) off = -off;
    lim = o.bucket ? tw : (tw * 3) / 2;
    spd = (off < lim) ? 12 : 30;
    if (cx < wl) begin
      settled_cnt = 0;
      return drive_cmd(-spd, spd,
                       o.bucket ? vsdd_pkg::ACT_BUCKET_LEFT : vsdd_pkg::ACT_BALL_LEFT, 1'b0);
    end
    if (cx > wr) begin
      settled_cnt = 0;
      return drive_cmd(spd, -spd,
                       o.bucket ? vsdd_pkg::ACT_BUCKET_RIGHT : vsdd_pkg::ACT_BALL_RIGHT, 1'b0);
    end
    if (!o.bucket) begin
      err = cx - tcx;
      if ((err < 0 ? -err : err) > ctol) begin
        settled_cnt = 0;
        if (err < 0) return drive_cmd(-8, 8, vsdd_pkg::ACT_FINE_LEFT, 1'b0);
        return drive_cmd(8, -8, vsdd_pkg::ACT_FINE_RIGHT, 1'b0);
      end
      if (pos < tsz - stol) begin
        settled_cnt = 0;
        spd = (pos * 8 > tsz * 10) ? 8 : 35;
        return drive_cmd(spd, spd, vsdd_pkg::ACT_BALL_FWD, 1'b0);
      end
      if (pos > tsz + stol) begin
        settled_cnt = 0;
        return drive_cmd(-12, -12, vsdd_pkg::ACT_BALL_BACK, 1'b0);
      end
    end else begin
      // size below floor(2.1 times the target), in integers
      if (10 * (pos + 1) <= 21 * tsz) begin
        settled_cnt = 0;
        return drive_cmd(25, 25, vsdd_pkg::ACT_BUCKET_FWD, 1'b0);
      end
      if (pos > tsz * 3) begin
        settled_cnt = 0;
        return drive_cmd(-12, -12, vsdd_pkg::ACT_BUCKET_BACK, 1'b0);
      end
    end
    if (settled_cnt < 65535) settled_cnt++;
    return drive_cmd(0, 0,
                     o.bucket ? vsdd_pkg::ACT_BUCKET_READY : vsdd_pkg::ACT_BALL_READY,
                     settled_cnt > cfg_q[vsdd_pkg::CFG_STABLE_FRAMES]);
  endfunction

  function automatic void dir_row(bit ns, bit v, bit b, int x, int w, int h,
                                  bit typed = 1'b0, vsdd_pkg::result_t want = '0);
    dir_row_t r;
    r.new_setting = ns;
    r.o           = '{v, b, clip12(x), clip12(w), clip12(h)};
    r.typed       = typed;
    r.want        = want;
    dir_tab.push_back(r);
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Offer one frame, hold it until the transfer, then record what it should produce.
  task automatic send_item(obs_t o, bit typed = 1'b0, vsdd_pkg::result_t want = '0);
    vsdd_pkg::result_t pred;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_target_visible <= o.visible;
    in_bucket_mode    <= o.bucket;
    in_target_x       <= o.x;
    in_box_width      <= o.w;
    in_box_height     <= o.h;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = decide_drive(o);
    drive_q.push_back(typed ? want : pred);
    frames_sent++;
  endtask

  task automatic idle_gap();
    int n, sel;
    sel = $urandom_range(0, 99);
    if (tx_steady || sel < 55) n = 0;
    else if (sel < 85) n = $urandom_range(1, 3);
    else if (sel < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result plus pipeline slack.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input int vals [8]);
    int i;
    for (i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= vsdd_pkg::cfg_reg_t'(i);
      cfg_data  <= vals[i][11:0];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      cfg_q[i] = (i == vsdd_pkg::CFG_STABLE_FRAMES) ? (vals[i] & 'h3FF) : (vals[i] & 'hFFF);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Receiver: runs of accepting and stalling, plus one long hold on request.
  initial begin : rx_stall
    int run_left, k;
    bit stalling;
    out_stall = 1'b0;
    run_left  = 0;
    stalling  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          k = $urandom_range(0, 99);
          stalling = (k >= 60);
          if (k < 60) run_left = $urandom_range(1, 20);
          else if (k < 90) run_left = $urandom_range(1, 3);
          else if (k < 98) run_left = $urandom_range(4, 10);
          else run_left = $urandom_range(20, 60);
        end
        out_stall <= stalling;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    vsdd_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (drive_q.size() == 0) begin
        report("result transfer with no frame outstanding");
      end else begin
        want = drive_q.pop_front();
        if (out_left_speed !== want.spd_left || out_right_speed !== want.spd_right ||
            out_action_code !== want.action_code || out_is_idle !== want.is_idle ||
            out_reached !== want.reached)
          report({$sformatf("got L=%0d R=%0d act=%0d idle=%0b rch=%0b", out_left_speed,
                            out_right_speed, out_action_code, out_is_idle, out_reached),
                  $sformatf(", want L=%0d R=%0d act=%0d idle=%0b rch=%0b", want.spd_left,
                            want.spd_right, want.action_code, want.is_idle, want.reached)});
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, drive_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int p, i, sel, sz, tcx, tsz, x;
    int setting [8];
    int dir_b [8];
    obs_t o, prev;

    errors        = 0;
    frames_sent   = 0;
    results_seen  = 0;
    settings_used = 0;
    hold_req      = 1'b0;
    tx_steady     = 1'b0;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = vsdd_pkg::CFG_WINDOW_LEFT;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_target_visible = 1'b0;
    in_bucket_mode    = 1'b0;
    in_target_x       = '0;
    in_box_width      = '0;
    in_box_height     = '0;
    cfg_q = '{0, 4095, 2048, 0, 155, 0, 0, 0};
    settled_cnt = 0;
    seen_any    = 1'b0;
    seen_x      = 0;
    prev        = '0;

    // reset settings first, then a 1000 to 3000 window with its center at column 1050
    dir_row(0, 0, 0, 0, 0, 0, 1, drive_cmd(0, 0, vsdd_pkg::ACT_IDLE, 0));
    dir_row(0, 0, 1, 0, 0, 0, 1, drive_cmd(12, -12, vsdd_pkg::ACT_BUCKET_SEARCH, 0));
    dir_row(0, 1, 0, 2048, 155, 0, 1, drive_cmd(0, 0, vsdd_pkg::ACT_BALL_READY, 1));
    dir_row(0, 1, 0, 0, 0, 0, 1, drive_cmd(-8, 8, vsdd_pkg::ACT_FINE_LEFT, 0));
    dir_row(0, 0, 0, 4095, 4095, 4095, 1, drive_cmd(-30, 30, vsdd_pkg::ACT_SEARCH_LEFT, 0));
    dir_row(0, 1, 0, 4095, 4095, 4095, 1, drive_cmd(8, -8, vsdd_pkg::ACT_FINE_RIGHT, 0));
    dir_row(0, 0, 0, 0, 0, 0, 1, drive_cmd(30, -30, vsdd_pkg::ACT_SEARCH_RIGHT, 0));
    dir_row(0, 1, 0, 2048, 0, 0, 1, drive_cmd(35, 35, vsdd_pkg::ACT_BALL_FWD, 0));
    dir_row(0, 1, 0, 2048, 4095, 10, 1, drive_cmd(-12, -12, vsdd_pkg::ACT_BALL_BACK, 0));
    dir_row(0, 1, 0, 2048, 154, 154);
    dir_row(0, 1, 1, 2048, 0, 4095, 1, drive_cmd(25, 25, vsdd_pkg::ACT_BUCKET_FWD, 0));
    dir_row(0, 1, 1, 0, 324, 4000);
    dir_row(0, 1, 1, 4095, 325, 4000);
    dir_row(0, 1, 1, 100, 465, 465);
    dir_row(0, 1, 1, 100, 466, 500, 1, drive_cmd(-12, -12, vsdd_pkg::ACT_BUCKET_BACK, 0));
    dir_row(0, 1, 1, 4095, 4095, 4095, 1, drive_cmd(-12, -12, vsdd_pkg::ACT_BUCKET_BACK, 0));
    dir_row(1, 1, 0, 999, 0, 0);
    dir_row(0, 1, 1, 999, 50, 50);
    dir_row(0, 1, 0, 3001, 150, 0);
    dir_row(0, 1, 0, 1070, 150, 0);
    dir_row(0, 1, 0, 1070, 150, 0);
    dir_row(0, 1, 0, 1070, 150, 0);
    dir_row(0, 1, 0, 1071, 150, 0);
    dir_row(0, 1, 0, 1050, 144, 0);
    dir_row(0, 1, 0, 1050, 0, 166);
    dir_row(0, 0, 0, 1050, 0, 0);
    dir_b = '{1000, 3000, 1050, 100, 155, 20, 10, 2};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].new_setting) begin
        drain();
        write_setting(dir_b);
      end
      send_item(dir_tab[i].o, dir_tab[i].typed, dir_tab[i].want);
      idle_gap();
    end
    drain();

    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: setting = '{0, 0, 0, 0, 0, 0, 0, 0};
        1: setting = '{4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095};
        2: begin
          setting[0] = $urandom_range(2048, 4095);
          setting[1] = $urandom_range(0, 2047);
          for (i = 2; i < 8; i++) setting[i] = $urandom_range(0, 4095);
        end
        default: begin
          setting[0] = $urandom_range(0, 1500);
          setting[1] = $urandom_range(2500, 4095);
          setting[2] = $urandom_range(setting[0], setting[1]);
          setting[3] = $urandom_range(0, 400);
          setting[4] = $urandom_range(10, 1300);
          setting[5] = $urandom_range(0, 150);
          setting[6] = $urandom_range(0, 150);
          setting[7] = $urandom_range(0, 12) | ($urandom_range(0, 3) << 10);
        end
      endcase
      write_setting(setting);
      tx_steady = (p == 3) || ($urandom_range(0, 3) == 0);
      if (p == 3) hold_req = 1'b1;

      for (i = 0; i < PHASE_FRAMES; i++) begin
        if (p == 5 && i == PHASE_FRAMES / 2) drain();
        tcx = cfg_q[vsdd_pkg::CFG_TARGET_CENTER_X];
        tsz = cfg_q[vsdd_pkg::CFG_TARGET_SIZE];
        sel = $urandom_range(0, 99);
        o.visible = 1'b1;
        o.bucket  = 1'($urandom_range(0, 1));
        o.x = clip12($urandom_range(0, 4095));
        o.w = clip12($urandom_range(0, 4095));
        o.h = clip12($urandom_range(0, 4095));
        if (sel < 20) begin
          o = prev;                      // repeat to build settled runs
        end else if (sel < 32) begin
          o.visible = 1'b0;
        end else if (sel >= 50) begin
          // steer toward the decision boundaries
          case ($urandom_range(0, 3))
            0: x = tcx + $urandom_range(0, 2 * cfg_q[vsdd_pkg::CFG_CENTER_TOL] + 6)
                 - cfg_q[vsdd_pkg::CFG_CENTER_TOL] - 3;
            1: x = cfg_q[vsdd_pkg::CFG_WINDOW_LEFT] + $urandom_range(0, 6) - 3;
            2: x = cfg_q[vsdd_pkg::CFG_WINDOW_RIGHT] + $urandom_range(0, 6) - 3;
            default: x = tcx + $urandom_range(0, 4 * cfg_q[vsdd_pkg::CFG_TARGET_WIDTH] + 2)
                       - 2 * cfg_q[vsdd_pkg::CFG_TARGET_WIDTH] - 1;
          endcase
          o.x = clip12(x);
          if (!o.bucket) begin
            sz = tsz + $urandom_range(0, 2 * cfg_q[vsdd_pkg::CFG_SIZE_TOL] + 8)
                 - cfg_q[vsdd_pkg::CFG_SIZE_TOL] - 4;
            o.w = clip12(sz);
            o.h = clip12(sz - $urandom_range(0, 50));
          end else begin
            case ($urandom_range(0, 2))
              0: sz = (21 * tsz) / 10 + $urandom_range(0, 6) - 3;
              1: sz = 3 * tsz + $urandom_range(0, 6) - 3;
              default: sz = $urandom_range((21 * tsz) / 10, 3 * tsz);
            endcase
            o.w = clip12(sz);
            o.h = clip12(sz + $urandom_range(0, 50));
          end
        end
        send_item(o);
        prev = o;
        idle_gap();
      end
      drain();
    end

    while (hold_req) @(posedge clk);
    drain();
    repeat (10) @(posedge clk);
    $display("Run covered %0d frames and %0d checked results over %0d register settings,",
             frames_sent, results_seen, settings_used);
    $display("including a long receiver hold with the input backed up and a full drain.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
design/vsdd_pkg.sv
design/vsdd_decide.sv
design/visual_servo_drive_decider.sv
tb/tb_visual_servo_drive_decider.sv
